// File: src/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and codes shared by the retransmit tracking table.
// ----------------------------------------------------------------------------
package rtt_pkg;

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_RECV = 2'd1,
    ACT_TICK = 2'd2
  } rtt_action_e;

  typedef enum logic [1:0] {
    EV_TRANSMIT = 2'd0,
    EV_DELIVER  = 2'd1,
    EV_RESEND   = 2'd2
  } rtt_event_e;

  localparam logic CFG_RESEND_INTERVAL = 1'b0;
  localparam logic CFG_MAX_TRIES       = 1'b1;

  localparam logic [7:0] RESET_INTERVAL = 8'd3;
  localparam logic [7:0] RESET_MAX      = 8'd3;
  localparam logic [7:0] SAT_MAX        = 8'hFF;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_push;
    logic [15:0] cmd;
    logic [31:0] seq;
    logic [15:0] packet_ref;
  } rtt_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] out_cmd;
    logic [31:0] out_seq;
    logic [15:0] out_ref;
    logic        matched;
    logic        table_full;
    logic        last;
  } rtt_out_t;

  typedef struct packed {
    logic [15:0] cmd;
    logic [31:0] seq;
    logic [15:0] pref;
    logic [7:0]  tries;
    logic [7:0]  age;
  } rtt_entry_t;

  typedef struct packed {
    logic       keep;
    logic       hit;
    logic       resend;
    rtt_entry_t entry;
  } rtt_eval_t;

endpackage

// File: src/rtt_mem.sv
// ----------------------------------------------------------------------------
// rtt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtt_mem #(
  parameter int Depth = 16,
  parameter int Width = 80
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/rtt_eval.sv
// ----------------------------------------------------------------------------
// rtt_eval
// Shared per-entry unit: ages an entry on a tick, or matches it on a receive.
// ----------------------------------------------------------------------------
module rtt_eval
  import rtt_pkg::*;
(
  input  rtt_entry_t  entry_i,
  input  logic        tick_i,
  input  logic [15:0] key_cmd_i,
  input  logic [31:0] key_seq_i,
  input  logic        hit_i,
  input  logic [7:0]  interval_i,
  input  logic [7:0]  max_tries_i,
  output rtt_eval_t   eval_o
);

  logic [7:0] age_inc;
  logic       expired;
  logic       drop;
  logic       match;

  always_comb begin
    age_inc = (entry_i.age == SAT_MAX) ? entry_i.age : entry_i.age + 8'd1;
    expired = age_inc >= interval_i;
    drop    = expired && (entry_i.tries >= max_tries_i);
    match   = !hit_i && (entry_i.cmd == key_cmd_i) && (entry_i.seq == key_seq_i);

    eval_o = '0;
    eval_o.entry = entry_i;
    if (tick_i) begin
      eval_o.keep   = !drop;
      eval_o.resend = expired && !drop;
      eval_o.entry.age = age_inc;
      if (expired && !drop) begin
        eval_o.entry.age = '0;
        if (entry_i.tries != SAT_MAX) begin
          eval_o.entry.tries = entry_i.tries + 8'd1;
        end
      end
    end else begin
      eval_o.keep = !match;
      eval_o.hit  = match;
    end
  end

endmodule

// File: src/retransmit_tracking_table.sv
// Receive push and tick walk the stored entries through the single entry-memory
// read port feeding the shared evaluation unit; output back-pressure adds stalls.
// One word is in flight at a time; a new word is taken once the last result
// sits in the output register. Reset empties the table (count to zero) and
// sets resend interval and max tries to 3; entry contents are not cleared.
// ----------------------------------------------------------------------------
// retransmit_tracking_table
// Table of outstanding push packets with resend aging and ack removal.
// ----------------------------------------------------------------------------
module retransmit_tracking_table
  import rtt_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rtt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rtt_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [7:0] interval_q, interval_d;
  logic [7:0] max_tries_q, max_tries_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] w_q, w_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;

  logic [1:0]  op_q, op_d;
  logic        push_q, push_d;
  logic [15:0] cmd_q, cmd_d;
  logic [31:0] seq_q, seq_d;
  logic [15:0] ref_q, ref_d;

  logic     out_valid_q, out_valid_d;
  rtt_out_t out_q, out_d;
  logic     pend_valid_q, pend_valid_d;
  rtt_out_t pend_q, pend_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  rtt_entry_t       mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic [$bits(rtt_entry_t)-1:0] mem_rdata;
  rtt_entry_t       rd_entry;
  rtt_eval_t        ev;

  logic out_free;
  logic last_idx;
  logic stall;
  logic is_full;

  assign rd_entry = rtt_entry_t'(mem_rdata);

  rtt_mem #(
    .Depth (TABLE_DEPTH),
    .Width ($bits(rtt_entry_t))
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rtt_eval u_eval (
    .entry_i     (rd_entry),
    .tick_i      (op_q == ACT_TICK),
    .key_cmd_i   (cmd_q),
    .key_seq_i   (seq_q),
    .hit_i       (hit_q),
    .interval_i  (interval_q),
    .max_tries_i (max_tries_q),
    .eval_o      (ev)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign last_idx    = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
  assign stall       = ev.resend && pend_valid_q && !out_free;
  assign is_full     = count_q == FULL_CNT;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d      = state_q;
    interval_d   = interval_q;
    max_tries_d  = max_tries_q;
    count_d      = count_q;
    w_d          = w_q;
    idx_d        = idx_q;
    hit_d        = hit_q;
    op_d         = op_q;
    push_d       = push_q;
    cmd_d        = cmd_q;
    seq_d        = seq_q;
    ref_d        = ref_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    mem_we       = 1'b0;
    mem_waddr    = w_q[IDX_W-1:0];
    mem_wdata    = ev.entry;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESEND_INTERVAL: interval_d  = cfg_data_i;
        CFG_MAX_TRIES:       max_tries_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = in_data_i.action;
          push_d = in_data_i.is_push;
          cmd_d  = in_data_i.cmd;
          seq_d  = in_data_i.seq;
          ref_d  = in_data_i.packet_ref;
          w_d    = '0;
          idx_d  = '0;
          hit_d  = 1'b0;
          unique case (in_data_i.action)
            ACT_SEND: state_d = S_FINISH;
            ACT_RECV, ACT_TICK: begin
              if (count_q != '0 && (in_data_i.is_push || in_data_i.action == ACT_TICK)) begin
                mem_re  = 1'b1;
                state_d = S_SCAN;
              end else begin
                state_d = S_FINISH;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          mem_we = ev.keep;
          if (ev.keep) begin
            w_d = w_q + CNT_W'(1);
          end
          if (ev.hit) begin
            hit_d = 1'b1;
          end
          if (ev.resend) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
            end
            pend_valid_d       = 1'b1;
            pend_d             = '0;
            pend_d.event_kind  = EV_RESEND;
            pend_d.out_cmd     = rd_entry.cmd;
            pend_d.out_seq     = rd_entry.seq;
            pend_d.out_ref     = rd_entry.pref;
          end
          if (last_idx) begin
            count_d = w_d;
            state_d = S_FINISH;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_q + IDX_W'(1);
            idx_d     = idx_q + IDX_W'(1);
          end
        end
      end

      S_FINISH: begin
        if (op_q == ACT_TICK) begin
          if (!pend_valid_q) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            out_valid_d  = 1'b1;
            out_d        = pend_q;
            out_d.last   = 1'b1;
            pend_valid_d = 1'b0;
            state_d      = S_IDLE;
          end
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_d          = '0;
          out_d.out_cmd  = cmd_q;
          out_d.out_seq  = seq_q;
          out_d.out_ref  = ref_q;
          out_d.last     = 1'b1;
          if (op_q == ACT_SEND) begin
            out_d.event_kind = EV_TRANSMIT;
            out_d.table_full = push_q && is_full;
            if (push_q && !is_full) begin
              mem_we          = 1'b1;
              mem_waddr       = count_q[IDX_W-1:0];
              mem_wdata.cmd   = cmd_q;
              mem_wdata.seq   = seq_q;
              mem_wdata.pref  = ref_q;
              mem_wdata.tries = 8'd1;
              mem_wdata.age   = '0;
              count_d         = count_q + CNT_W'(1);
            end
          end else begin
            out_d.event_kind = EV_DELIVER;
            out_d.matched    = hit_q;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      interval_q   <= RESET_INTERVAL;
      max_tries_q  <= RESET_MAX;
      count_q      <= '0;
      w_q          <= '0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      interval_q   <= interval_d;
      max_tries_q  <= max_tries_d;
      count_q      <= count_d;
      w_q          <= w_d;
      idx_q        <= idx_d;
      hit_q        <= hit_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    push_q <= push_d;
    cmd_q  <= cmd_d;
    seq_q  <= seq_d;
    ref_q  <= ref_d;
    out_q  <= out_d;
    pend_q <= pend_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("entry count exceeds table depth");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && mem_we) |-> (w_q <= CNT_W'(idx_q)))
    else $error("compaction write ahead of read");

  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != S_IDLE))
    else $error("pending resend left behind in idle");

  a_scan_has_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (count_q != '0))
    else $error("scan over empty table");
`endif

endmodule
